[hw/rtl/lsc_pkg.sv]
// Shared types, constants and codes of the layer suitability combiner.
package lsc_pkg;

  localparam int MaxLayers     = 6;
  localparam int ValueFracBits = 15;
  localparam int WeightFracBits = 12;
  localparam int NumWeights    = 6;
  localparam int SumWidth      = 35;
  localparam int CountWidth    = 3;

  localparam logic [2:0] MethodProduct = 3'd0;
  localparam logic [2:0] MethodMean    = 3'd1;
  localparam logic [2:0] MethodGeo     = 3'd2;
  localparam logic [2:0] MethodMin     = 3'd3;
  localparam logic [2:0] MethodWeight  = 3'd4;

  localparam logic [1:0] KindValid  = 2'd0;
  localparam logic [1:0] KindNodata = 2'd1;

  localparam logic [15:0] WeightReset = 16'd4096;

  // Closed pixel handed from the accumulating front part to the finishing back part.
  typedef struct packed {
    logic                  nodata;
    logic [2:0]            method;
    logic [CountWidth-1:0] count;
    logic [SumWidth-1:0]   sum;
    logic [16:0]           prod;
    logic [15:0]           min;
  } pixel_t;

endpackage

[hw/rtl/lsc_front.sv]
// Front part: accumulates layer items and closes a pixel into the queue.
module lsc_front #(
  parameter int MAX_LAYERS = lsc_pkg::MaxLayers
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            layer,
  input  logic [15:0]           value,
  input  logic [1:0]            kind,
  input  logic                  last_layer,
  input  logic [2:0]            method,
  input  logic [15:0]           weight [lsc_pkg::NumWeights],
  output logic                  pix_valid,
  input  logic                  pix_ready,
  output lsc_pkg::pixel_t       pix
);

  localparam int VALUE_FRAC_BITS = lsc_pkg::ValueFracBits;
  localparam int PW = VALUE_FRAC_BITS + 2;
  localparam logic [PW-1:0] ProdMax = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] OneVal = PW'(1) << VALUE_FRAC_BITS;

  logic [PW-1:0] product_acc;
  logic [lsc_pkg::SumWidth-1:0] sum_acc;
  logic [15:0] min_acc;
  logic [lsc_pkg::CountWidth-1:0] value_count;
  logic nodata_seen;

  logic take, use_val;
  logic [15:0] w;
  logic [PW+15:0] mul_full;
  logic [PW-1:0] prod_next;
  logic [lsc_pkg::SumWidth-1:0] sum_next;
  logic [15:0] min_next;
  logic [lsc_pkg::CountWidth-1:0] count_next;
  logic nod_next;

  // The queue stage holds one closed pixel; accumulation stalls only on a close.
  assign in_ready = !pix_valid || pix_ready || !last_layer;
  assign take = in_valid && in_ready;
  assign use_val = (kind == lsc_pkg::KindValid) &&
                   (value_count < lsc_pkg::CountWidth'(MAX_LAYERS));

  always_comb begin
    w = 16'(1 << lsc_pkg::WeightFracBits);
    if (method == lsc_pkg::MethodWeight) begin
      w = 16'd0;
      for (int i = 0; i < lsc_pkg::NumWeights; i++) begin
        if (i < MAX_LAYERS && layer == 3'(i)) w = weight[i];
      end
    end
    mul_full = product_acc * value;
    prod_next = product_acc;
    sum_next = sum_acc;
    min_next = min_acc;
    count_next = value_count;
    nod_next = nodata_seen || (kind == lsc_pkg::KindNodata);
    if (use_val) begin
      if ((mul_full >> VALUE_FRAC_BITS) > (PW+16)'(ProdMax)) prod_next = ProdMax;
      else prod_next = PW'(mul_full >> VALUE_FRAC_BITS);
      sum_next = sum_acc + lsc_pkg::SumWidth'(value * w);
      if (value_count == '0 || value < min_acc) min_next = value;
      count_next = value_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product_acc <= OneVal;
      sum_acc <= '0;
      min_acc <= 16'(OneVal);
      value_count <= '0;
      nodata_seen <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (take && last_layer) pix_valid <= 1'b1;
      else if (pix_ready) pix_valid <= 1'b0;
      if (take) begin
        if (last_layer) begin
          pix.nodata <= nod_next;
          pix.method <= method;
          pix.count <= count_next;
          pix.sum <= sum_next;
          pix.prod <= 17'(prod_next);
          pix.min <= min_next;
          product_acc <= OneVal;
          sum_acc <= '0;
          min_acc <= 16'(OneVal);
          value_count <= '0;
          nodata_seen <= 1'b0;
        end else begin
          product_acc <= prod_next;
          sum_acc <= sum_next;
          min_acc <= min_next;
          value_count <= count_next;
          nodata_seen <= nod_next;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    value_count <= lsc_pkg::CountWidth'(MAX_LAYERS)) else $error("count overflow");
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    take && last_layer |=> value_count == '0 && !nodata_seen) else $error("no clear");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix)) else $error("pixel lost");
`endif

endmodule

[hw/rtl/lsc_back.sv]
// Back part: divides, takes the bitwise root of, or passes on a closed pixel and holds the result.
module lsc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_ready,
  input  lsc_pkg::pixel_t pix,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     combined,
  output logic            is_nodata,
  output logic            saturated
);

  localparam int VALUE_FRAC_BITS = lsc_pkg::ValueFracBits;
  localparam int PW = VALUE_FRAC_BITS + 2;
  localparam logic [PW-1:0] ProdMax = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] OneVal = PW'(1) << VALUE_FRAC_BITS;
  localparam int SW = lsc_pkg::SumWidth;
  localparam int BW = $clog2(SW + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIV = 4'b0010, S_ROOT = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state;
  lsc_pkg::pixel_t p;
  logic [SW-1:0] quo, rem_q;
  logic [SW:0] rem_try;
  logic [BW-1:0] bit_idx;
  logic [PW-1:0] root, cand, powv;
  logic [lsc_pkg::CountWidth-1:0] pow_cnt;
  logic [PW+PW-1:0] pow_mul;
  logic [PW-1:0] pow_step;
  logic [SW-1:0] res_wide;

  assign pix_ready = (state == S_IDLE);
  assign rem_try = {rem_q, p.sum[bit_idx[$clog2(SW)-1:0]]};
  assign cand = root | (PW'(1) << bit_idx);
  assign pow_mul = powv * cand;

  always_comb begin
    if ((pow_mul >> VALUE_FRAC_BITS) > (PW+PW)'(ProdMax)) pow_step = ProdMax;
    else pow_step = PW'(pow_mul >> VALUE_FRAC_BITS);
  end

  always_comb begin
    case (p.method)
      lsc_pkg::MethodProduct: res_wide = SW'(p.prod);
      lsc_pkg::MethodMean, lsc_pkg::MethodWeight: res_wide = quo >> lsc_pkg::WeightFracBits;
      lsc_pkg::MethodGeo: res_wide = SW'(root);
      default: res_wide = SW'(p.min);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pix_valid) begin
            p <= pix;
            quo <= '0;
            rem_q <= '0;
            root <= '0;
            powv <= OneVal;
            pow_cnt <= '0;
            if (pix.nodata || pix.count == '0 || pix.method > lsc_pkg::MethodWeight ||
                pix.method == lsc_pkg::MethodProduct || pix.method == lsc_pkg::MethodMin)
              state <= S_DONE;
            else if (pix.method == lsc_pkg::MethodGeo) begin
              bit_idx <= BW'(VALUE_FRAC_BITS);
              state <= S_ROOT;
            end else begin
              bit_idx <= BW'(SW - 1);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (rem_try >= (SW+1)'(p.count)) begin
            rem_q <= SW'(rem_try - (SW+1)'(p.count));
            quo <= quo | (SW'(1) << bit_idx);
          end else rem_q <= SW'(rem_try);
          if (bit_idx == '0) state <= S_DONE;
          else bit_idx <= bit_idx - 1'b1;
        end
        S_ROOT: begin
          // One candidate multiply per cycle; count multiplies give its power.
          if (pow_cnt == p.count) begin
            if (powv <= PW'(p.prod)) root <= cand;
            powv <= OneVal;
            pow_cnt <= '0;
            if (bit_idx == '0) state <= S_DONE;
            else bit_idx <= bit_idx - 1'b1;
          end else begin
            powv <= pow_step;
            pow_cnt <= pow_cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (p.nodata || p.count == '0 || p.method > lsc_pkg::MethodWeight) begin
              combined <= '0;
              is_nodata <= 1'b1;
              saturated <= 1'b0;
            end else begin
              is_nodata <= 1'b0;
              saturated <= res_wide > SW'(OneVal);
              combined <= (res_wide > SW'(OneVal)) ? 16'(OneVal) : 16'(res_wide);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_sat_nod: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_nodata && saturated)) else $error("sat with nodata");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> combined <= 16'(OneVal)) else $error("result above one");
`endif

endmodule

[hw/rtl/layer_suitability_combiner.sv]
// Top level of the layer suitability combiner: front accumulator, pixel queue, back finisher.
//
//   channel | direction | handshake                | payload
//   s_axis  | in        | s_axis_tvalid/tready     | tdata {value,layer}, tuser kind, tlast
//   m_axis  | out       | m_axis_tvalid/tready     | tdata {saturated,is_nodata,combined}
//   cfg     | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// Each layer transaction is absorbed by the front accumulator.
// In the back finisher a closed pixel goes from S_IDLE straight to S_DONE for product,
// minimum and nodata; the means pass through S_DIV (one quotient bit per cycle over the
// 35-bit sum) and the geometric mean of n values through S_ROOT (one multiply a cycle).
// Reset (rst, synchronous) restores the weights to 1.0, the method to product.
// The front stalls only when a pixel closes while the queue still holds one.
module layer_suitability_combiner #(
  parameter int MAX_LAYERS = lsc_pkg::MaxLayers
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [2:0] layer, [18:3] value, zero fill
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  input  logic        s_axis_tlast,  // last_layer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] combined, [16] is_nodata, [17] saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [2:0] method;
  logic [15:0] weight [lsc_pkg::NumWeights];
  logic pix_valid, pix_ready;
  lsc_pkg::pixel_t pix;
  logic [15:0] combined;
  logic is_nodata, saturated;

  // Configuration writes are always taken; out-of-range indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      method <= lsc_pkg::MethodProduct;
      for (int i = 0; i < lsc_pkg::NumWeights; i++) weight[i] <= lsc_pkg::WeightReset;
    end else if (cfg_valid) begin
      if (cfg_index == 3'd0) method <= cfg_data[2:0];
      for (int i = 0; i < lsc_pkg::NumWeights; i++) begin
        if (cfg_index == 3'(i + 1)) weight[i] <= cfg_data;
      end
    end
  end

  lsc_front #(.MAX_LAYERS(MAX_LAYERS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .layer(s_axis_tdata[2:0]), .value(s_axis_tdata[18:3]),
    .kind(s_axis_tuser), .last_layer(s_axis_tlast),
    .method, .weight,
    .pix_valid, .pix_ready, .pix
  );

  lsc_back u_back (
    .clk, .rst, .pix_valid, .pix_ready, .pix,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .combined, .is_nodata, .saturated
  );

  assign m_axis_tdata = {6'd0, saturated, is_nodata, combined};

endmodule
